### sv/ffha_pkg.sv
// Package for the first-fit heap allocator: sizes, codes and item types.
// No dependencies.
package ffha_pkg;
  localparam int unsigned HeapBytes = 65536;
  localparam int unsigned HeapWords = HeapBytes / 4;
  localparam int unsigned AddrW = $clog2(HeapWords);
  localparam int unsigned StepCap = HeapBytes / 16 + 1;
  localparam int unsigned StepW = $clog2(StepCap + 1);
  localparam logic [31:0] NilLink = 32'hFFFF_FFFF;
  localparam logic [31:0] HdrBytes = 32'd16;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_BAD = 2'd1;
  localparam logic [1:0] ST_NOFIT = 2'd2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE = 1'b1;

  typedef struct packed {
    logic [16:0] chunk_bytes;
    logic [15:0] result_offset;
    logic [1:0] status;
  } res_t;
endpackage

### sv/first_fit_heap_allocator_unit.sv
// First-fit heap allocator top level: heap memory, list pointers, sequencer.
// Depends on ffha_pkg.
//
// The block keeps a heap of 64 KiB as 16384 words of 32 bits in one
// synchronous memory (one read port, one write port, read data registered)
// and manages it as a doubly linked free list. An allocate (op 0) walks the
// list first fit and takes or splits a chunk; a free (op 1) absorbs the
// following free chunks and pushes the result on the list front. One item is
// worked on at a time. After reset a clearing pass over every word writes the
// initial heap image; no item is taken meanwhile. An allocate reads the size
// and next link of each list chunk it passes over, then the prev link of the
// chunk found, and writes the new links and header; a split also writes the
// remainder's header. A free reads and clears the block header, then reads the
// header, size and links of each absorbed neighbour and unlinks it, and writes
// the merged chunk's size and links. Every memory read is one word through the
// single read port. The next item is taken in the cycle after the result is
// placed. The result sits in an output register so the next item may be
// accepted while it waits.
module first_fit_heap_allocator_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,  // request_bytes[15:0], block_offset[31:16]
  input  logic        in_tuser,  // op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata  // status[1:0], result_offset[17:2], chunk_bytes[34:18]
);

  typedef enum logic [20:0] {
    S_CLR   = 21'h000001,
    S_IDLE  = 21'h000002,
    S_ARD   = 21'h000004,  // issue read of size word of chunk c
    S_AW1   = 21'h000008,  // size in, issue read of word 3
    S_AW2   = 21'h000010,  // next in, decide
    S_AP    = 21'h000020,  // prev in
    S_AP2   = 21'h000040,  // never entered
    S_LNK   = 21'h000080,  // apply link writes
    S_LNK2  = 21'h000100,
    S_AHDR  = 21'h000200,  // write header word 0 of c
    S_NC0   = 21'h000400,
    S_NC1   = 21'h000800,
    S_NC2   = 21'h001000,
    S_FRD   = 21'h002000,  // read word 0 of block
    S_FCHK  = 21'h004000,
    S_MRD   = 21'h008000,  // read word 0 of neighbour
    S_MRD1  = 21'h010000,
    S_MRD2  = 21'h020000,
    S_MRD3  = 21'h040000,
    S_FWR   = 21'h080000,
    S_DONE  = 21'h100000
  } st_t;

  localparam int unsigned AW = ffha_pkg::AddrW;

  // heap memory
  logic [31:0] mem [ffha_pkg::HeapWords];
  logic [31:0] rdata_r;
  logic [AW-1:0] raddr;
  logic          we;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  localparam int unsigned StepW_L = ffha_pkg::StepW;
  st_t st_r, st_nxt;
  logic [31:0] lfirst_r, lfirst_nxt, llast_r, llast_nxt;
  logic [31:0] c_r, c_nxt;          // current chunk offset
  logic [31:0] csz_r, csz_nxt;      // current size / accumulated size
  logic [31:0] nx_r, nx_nxt;        // next link / neighbour offset
  logic [31:0] pv_r, pv_nxt;        // prev link
  logic [31:0] need_r, need_nxt;
  logic [StepW_L-1:0] steps_r, steps_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic        split_r, split_nxt;  // alloc: split the chunk found
  logic [1:0]  lstep_r, lstep_nxt;
  logic        merge_r, merge_nxt;
  logic        in_use_r, in_use_nxt;
  logic        out_v_r, out_v_nxt;
  ffha_pkg::res_t res_r, res_nxt;
  ffha_pkg::res_t ores_r, ores_nxt;  // result on the output channel

  // word address of offset + w; flag set when outside the heap
  function automatic logic [AW:0] widx(input logic [31:0] off, input logic [1:0] w);
    logic [31:0] i;
    i = {2'b00, off[31:2]} + {30'd0, w};
    widx = (i < ffha_pkg::HeapWords) ? {1'b0, i[AW-1:0]} : {1'b1, {AW{1'b0}}};
  endfunction

  logic [AW:0] ri, wi;
  logic [31:0] rsel;  // read data, 0 outside the heap
  logic        rout_r, rout_nxt;

  assign rsel = rout_r ? 32'd0 : rdata_r;
  assign in_tready = (st_r == S_IDLE) && !in_use_r;
  assign out_tvalid = out_v_r;
  assign out_tdata = {5'd0, ores_r.chunk_bytes, ores_r.result_offset, ores_r.status};

  logic [32:0] nneed;
  always_comb begin
    st_nxt = st_r; lfirst_nxt = lfirst_r; llast_nxt = llast_r;
    c_nxt = c_r; csz_nxt = csz_r; nx_nxt = nx_r; pv_nxt = pv_r; need_nxt = need_r;
    steps_nxt = steps_r; clr_nxt = clr_r; split_nxt = split_r; lstep_nxt = lstep_r;
    merge_nxt = merge_r; in_use_nxt = in_use_r; out_v_nxt = out_v_r; res_nxt = res_r;
    ores_nxt = ores_r;
    ri = '0; wi = {1'b1, {AW{1'b0}}}; wdata = '0; rout_nxt = 1'b0;
    nneed = '0;
    if (out_v_r && out_tready) out_v_nxt = 1'b0;
    if (in_use_r && !out_v_r) begin
      // result waiting to be placed
      ores_nxt = res_r;
      out_v_nxt = 1'b1; in_use_nxt = 1'b0;
    end
    unique case (st_r)
      S_CLR: begin
        wi = {1'b0, clr_r[AW-1:0]};
        unique case (clr_r[AW-1:0])
          AW'(1): wdata = ffha_pkg::HeapBytes;
          AW'(2), AW'(3): wdata = ffha_pkg::NilLink;
          default: wdata = '0;
        endcase
        clr_nxt = clr_r + 1'b1;
        if (clr_r[AW-1:0] == {AW{1'b1}}) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          steps_nxt = '0;
          if (in_tuser == ffha_pkg::OP_ALLOC) begin
            if (in_tdata[15:0] == 16'd0 ||
                {16'd0, in_tdata[15:0]} > ffha_pkg::HeapBytes / 2) begin
              res_nxt = '{status: ffha_pkg::ST_BAD, result_offset: '0, chunk_bytes: '0};
              st_nxt = S_DONE;
            end else begin
              nneed = {17'd0, in_tdata[15:0]} + 33'd4;
              if (nneed < 33'd16) nneed = 33'd16;
              nneed = (nneed + 33'd3) & ~33'd3;
              need_nxt = nneed[31:0];
              c_nxt = lfirst_r;
              st_nxt = S_ARD;
            end
          end else begin
            c_nxt = {16'd0, in_tdata[31:16]};
            if (in_tdata[17:16] != 2'b00 ||
                {16'd0, in_tdata[31:16]} + ffha_pkg::HdrBytes > ffha_pkg::HeapBytes) begin
              res_nxt = '{status: ffha_pkg::ST_BAD, result_offset: '0, chunk_bytes: '0};
              st_nxt = S_DONE;
            end else st_nxt = S_FRD;
          end
        end
      end
      S_ARD: begin
        if (c_r == ffha_pkg::NilLink || steps_r >= StepW_L'(ffha_pkg::StepCap)) begin
          res_nxt = '{status: ffha_pkg::ST_NOFIT, result_offset: '0, chunk_bytes: '0};
          st_nxt = S_DONE;
        end else begin
          ri = widx(c_r, 2'd1); rout_nxt = ri[AW];
          st_nxt = S_AW1;
        end
      end
      S_AW1: begin
        csz_nxt = rsel;
        ri = widx(c_r, 2'd3); rout_nxt = ri[AW];
        st_nxt = S_AW2;
      end
      S_AW2: begin
        nx_nxt = rsel;
        steps_nxt = steps_r + 1'b1;
        if (csz_r < need_r) begin
          c_nxt = rsel; st_nxt = S_ARD;
        end else begin
          split_nxt = (csz_r - need_r) >= 32'd16;
          ri = widx(c_r, 2'd2); rout_nxt = ri[AW];
          st_nxt = S_AP;
        end
      end
      S_AP: begin
        pv_nxt = rsel;
        if (split_r) begin
          nx_nxt = nx_r;
          st_nxt = S_NC0;
        end else begin
          lstep_nxt = 2'd0; st_nxt = S_LNK;
        end
      end
      S_NC0: begin
        wi = widx(c_r + need_r, 2'd0); wdata = '0;
        st_nxt = S_NC1;
      end
      S_NC1: begin
        wi = widx(c_r + need_r, 2'd1); wdata = csz_r - need_r;
        st_nxt = S_NC2;
      end
      S_NC2: begin
        wi = widx(c_r + need_r, 2'd2); wdata = pv_r;
        lstep_nxt = 2'd1; st_nxt = S_LNK;
      end
      S_LNK: begin
        // set_next(pv, X); X = n (unlink) or nc (split); also nc word 3
        if (lstep_r == 2'd1) begin
          wi = widx(c_r + need_r, 2'd3); wdata = nx_r;
          lstep_nxt = 2'd0;
        end else begin
          if (pv_r == ffha_pkg::NilLink) lfirst_nxt = split_r ? c_r + need_r : nx_r;
          else begin
            wi = widx(pv_r, 2'd3); wdata = split_r ? c_r + need_r : nx_r;
          end
          st_nxt = S_LNK2;
        end
      end
      S_LNK2: begin
        if (merge_r) begin
          // free merge unlink: set_prev(n, p) then continue
          if (nx_r == ffha_pkg::NilLink) llast_nxt = pv_r;
          else begin
            wi = widx(nx_r, 2'd2); wdata = pv_r;
          end
          csz_nxt = csz_r + need_r;
          st_nxt = S_MRD;
        end else begin
          if (nx_r == ffha_pkg::NilLink) llast_nxt = split_r ? c_r + need_r : pv_r;
          else begin
            wi = widx(nx_r, 2'd2); wdata = split_r ? c_r + need_r : pv_r;
          end
          st_nxt = S_AHDR;
        end
      end
      S_AHDR: begin
        wi = widx(c_r, 2'd0);
        wdata = split_r ? need_r : csz_r;
        res_nxt = '{status: ffha_pkg::ST_OK, result_offset: c_r[15:0],
                    chunk_bytes: split_r ? need_r[16:0] : csz_r[16:0]};
        st_nxt = S_DONE;
      end
      S_FRD: begin
        ri = widx(c_r, 2'd0); rout_nxt = ri[AW];
        st_nxt = S_FCHK;
      end
      S_FCHK: begin
        if (rsel == 32'd0 || rsel < 32'd16 || rsel[1:0] != 2'b00 ||
            {1'b0, c_r} + {1'b0, rsel} > 33'(ffha_pkg::HeapBytes)) begin
          res_nxt = '{status: ffha_pkg::ST_BAD, result_offset: '0, chunk_bytes: '0};
          st_nxt = S_DONE;
        end else begin
          csz_nxt = rsel;
          wi = widx(c_r, 2'd0); wdata = '0;
          merge_nxt = 1'b1; split_nxt = 1'b0;
          st_nxt = S_MRD;
        end
      end
      S_MRD: begin
        nx_nxt = c_r + csz_r;
        if (steps_r >= StepW_L'(ffha_pkg::StepCap) ||
            {1'b0, c_r} + {1'b0, csz_r} >= 33'(ffha_pkg::HeapBytes)) begin
          st_nxt = S_FWR; lstep_nxt = 2'd0;
        end else begin
          ri = widx(c_r + csz_r, 2'd0); rout_nxt = ri[AW];
          st_nxt = S_MRD1;
        end
      end
      S_MRD1: begin
        if (rsel != 32'd0) begin
          st_nxt = S_FWR; lstep_nxt = 2'd0;
        end else begin
          ri = widx(nx_r, 2'd1); rout_nxt = ri[AW];
          st_nxt = S_MRD2;
        end
      end
      S_MRD2: begin
        if (rsel < 32'd16 || rsel[1:0] != 2'b00 ||
            {1'b0, nx_r} + {1'b0, rsel} > 33'(ffha_pkg::HeapBytes)) begin
          st_nxt = S_FWR; lstep_nxt = 2'd0;
        end else begin
          need_nxt = rsel;  // neighbour size
          ri = widx(nx_r, 2'd2); rout_nxt = ri[AW];
          st_nxt = S_MRD3;
        end
      end
      S_MRD3: begin
        pv_nxt = rsel;
        ri = widx(nx_r, 2'd3); rout_nxt = ri[AW];
        steps_nxt = steps_r + 1'b1;
        lstep_nxt = 2'd2; st_nxt = S_LNK;
      end
      S_FWR: begin
        unique case (lstep_r)
          2'd0: begin wi = widx(c_r, 2'd1); wdata = csz_r; lstep_nxt = 2'd1; end
          2'd1: begin wi = widx(c_r, 2'd2); wdata = ffha_pkg::NilLink; lstep_nxt = 2'd2; end
          2'd2: begin wi = widx(c_r, 2'd3); wdata = lfirst_r; lstep_nxt = 2'd3; end
          default: begin
            if (lfirst_r == ffha_pkg::NilLink) llast_nxt = c_r;
            else begin
              wi = widx(lfirst_r, 2'd2); wdata = c_r;
            end
            lfirst_nxt = c_r;
            res_nxt = '{status: ffha_pkg::ST_OK, result_offset: c_r[15:0],
                        chunk_bytes: csz_r[16:0]};
            st_nxt = S_DONE;
          end
        endcase
      end
      S_DONE: begin
        in_use_nxt = 1'b1; merge_nxt = 1'b0;
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
    // merge-unlink link step: S_LNK entered from S_MRD3 with lstep 2
    if (st_r == S_LNK && lstep_r == 2'd2) begin
      nx_nxt = rsel;
      wi = {1'b1, {AW{1'b0}}};
      lstep_nxt = 2'd0;
      st_nxt = S_LNK;
    end
  end

  assign raddr = ri[AW-1:0];
  assign we = !wi[AW];
  assign waddr = wi[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR; clr_r <= '0; lfirst_r <= '0; llast_r <= '0;
      out_v_r <= 1'b0; in_use_r <= 1'b0; merge_r <= 1'b0; lstep_r <= '0;
      steps_r <= '0; rout_r <= 1'b0;
    end else begin
      st_r <= st_nxt; clr_r <= clr_nxt; lfirst_r <= lfirst_nxt; llast_r <= llast_nxt;
      out_v_r <= out_v_nxt; in_use_r <= in_use_nxt; merge_r <= merge_nxt;
      lstep_r <= lstep_nxt; steps_r <= steps_nxt; rout_r <= rout_nxt;
    end
    c_r <= c_nxt; csz_r <= csz_nxt; nx_r <= nx_nxt; pv_r <= pv_nxt;
    need_r <= need_nxt; split_r <= split_nxt; res_r <= res_nxt; ores_r <= ores_nxt;
  end

endmodule

### dv/ffha_checker.sv
// Checker for the first-fit heap allocator: watches both item channels,
// keeps its own heap image and free list, and compares every result.
// Depends on ffha_pkg.
`timescale 1ns / 100ps
module ffha_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  output int          fail_count,
  output int          pending
);
  logic [31:0] heap_img [ffha_pkg::HeapWords];
  logic [31:0] free_head;
  logic [31:0] free_tail;
  ffha_pkg::res_t due_q [$];

  function automatic logic [31:0] peek(longint unsigned off, int w);
    longint unsigned idx;
    idx = (off >> 2) + w;
    return (idx < ffha_pkg::HeapWords) ? heap_img[idx] : '0;
  endfunction

  function automatic void poke(longint unsigned off, int w, logic [31:0] v);
    longint unsigned idx;
    idx = (off >> 2) + w;
    if (idx < ffha_pkg::HeapWords) heap_img[idx] = v;
  endfunction

  function automatic void link_next(logic [31:0] node, logic [31:0] v);
    if (node == ffha_pkg::NilLink) free_head = v;
    else poke(node, 3, v);
  endfunction

  function automatic void link_prev(logic [31:0] node, logic [31:0] v);
    if (node == ffha_pkg::NilLink) free_tail = v;
    else poke(node, 2, v);
  endfunction

  function automatic void unlink(logic [31:0] c);
    logic [31:0] p, n;
    p = peek(c, 2);
    n = peek(c, 3);
    link_next(p, n);
    link_prev(n, p);
  endfunction

  function automatic bit chunk_sane(longint unsigned off, longint unsigned sz);
    return sz >= ffha_pkg::HdrBytes && sz[1:0] == 2'b00 && off + sz <= ffha_pkg::HeapBytes;
  endfunction

  function automatic ffha_pkg::res_t mk_res(logic [1:0] st, longint unsigned off,
                                            longint unsigned sz);
    ffha_pkg::res_t r;
    r.status = st;
    r.result_offset = off[15:0];
    r.chunk_bytes = sz[16:0];
    return r;
  endfunction

  function automatic ffha_pkg::res_t first_fit(logic [15:0] req);
    longint unsigned need, csz;
    logic [31:0] c, p, n, nc;
    if (req == 0 || req > ffha_pkg::HeapBytes / 2) return mk_res(ffha_pkg::ST_BAD, 0, 0);
    need = req + 4;
    if (need < ffha_pkg::HdrBytes) need = ffha_pkg::HdrBytes;
    need = (need + 3) & ~64'd3;
    c = free_head;
    for (int steps = 0; c != ffha_pkg::NilLink && steps < ffha_pkg::StepCap; steps++) begin
      csz = peek(c, 1);
      if (csz < need) begin
        c = peek(c, 3);
      end else if (csz - need < 16) begin
        unlink(c);
        poke(c, 0, csz[31:0]);
        return mk_res(ffha_pkg::ST_OK, c, csz);
      end else begin
        p = peek(c, 2);
        n = peek(c, 3);
        nc = c + need[31:0];
        poke(nc, 0, '0);
        poke(nc, 1, csz[31:0] - need[31:0]);
        poke(nc, 2, p);
        poke(nc, 3, n);
        link_next(p, nc);
        link_prev(n, nc);
        poke(c, 0, need[31:0]);
        return mk_res(ffha_pkg::ST_OK, c, need);
      end
    end
    return mk_res(ffha_pkg::ST_NOFIT, 0, 0);
  endfunction

  function automatic ffha_pkg::res_t release_block(logic [15:0] blk);
    longint unsigned off, sz, nx, nsz;
    off = blk;
    if (off[1:0] != 0 || off + ffha_pkg::HdrBytes > ffha_pkg::HeapBytes)
      return mk_res(ffha_pkg::ST_BAD, 0, 0);
    sz = peek(off, 0);
    if (sz == 0 || !chunk_sane(off, sz)) return mk_res(ffha_pkg::ST_BAD, 0, 0);
    poke(off, 0, '0);
    // forward merge only; stops at the heap end before touching a header
    for (int steps = 0; steps < ffha_pkg::StepCap; steps++) begin
      nx = off + sz;
      if (nx >= ffha_pkg::HeapBytes) break;
      if (peek(nx, 0) != 0) break;
      nsz = peek(nx, 1);
      if (!chunk_sane(nx, nsz)) break;
      unlink(nx[31:0]);
      sz += nsz;
    end
    poke(off, 1, sz[31:0]);
    poke(off, 2, ffha_pkg::NilLink);
    poke(off, 3, free_head);
    link_prev(free_head, off[31:0]);
    free_head = off[31:0];
    return mk_res(ffha_pkg::ST_OK, off, sz);
  endfunction

  always @(posedge clk) begin
    ffha_pkg::res_t got, want;
    if (!rst_n) begin
      for (int i = 0; i < ffha_pkg::HeapWords; i++) heap_img[i] = '0;
      heap_img[1] = ffha_pkg::HeapBytes;
      heap_img[2] = ffha_pkg::NilLink;
      heap_img[3] = ffha_pkg::NilLink;
      free_head = '0;
      free_tail = '0;
      due_q.delete();
      fail_count = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        if (in_tuser == ffha_pkg::OP_ALLOC)
          due_q.insert(due_q.size(), first_fit(in_tdata[15:0]));
        else due_q.insert(due_q.size(), release_block(in_tdata[31:16]));
      end
      if (out_tvalid && out_tready) begin
        got = ffha_pkg::res_t'(out_tdata[34:0]);
        if (due_q.size() == 0) begin
          $error("unexpected item: %h", out_tdata);
          fail_count++;
        end else begin
          want = due_q.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_count++;
          end
          if (got.result_offset !== want.result_offset) begin
            $error("result_offset: expected %0d, got %0d",
                   want.result_offset, got.result_offset);
            fail_count++;
          end
          if (got.chunk_bytes !== want.chunk_bytes) begin
            $error("chunk_bytes: expected %0d, got %0d",
                   want.chunk_bytes, got.chunk_bytes);
            fail_count++;
          end
        end
      end
    end
    pending = due_q.size();
  end
endmodule

### dv/tb.sv
// Top of the allocator testbench: clock, reset, item stimulus and verdict.
// Depends on ffha_pkg, ffha_checker and first_fit_heap_allocator_unit.
`timescale 1ns / 100ps
module tb;

  localparam int RandItems = 1050;
  localparam int CycleLimit = 40_000_000;  // includes the clearing pass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  int          fail_count, pending;
  int          cycles = 0;
  bit          calm = 1'b0;      // no idling on either side while set
  int          n_alloc = 0, n_free = 0;

  logic        issued_op [$];    // ops in flight, oldest first
  logic [15:0] live_blocks [$];  // allocated and not yet freed
  logic [15:0] freed_blocks [$]; // history, for stale frees at the end

  always #4 clk = ~clk;

  first_fit_heap_allocator_unit i_dut (.*);

  ffha_checker i_chk (.*);

  // sink: random back-pressure
  always @(posedge clk)
    out_tready <= calm || ($urandom_range(0, 99) >= 31);

  // learn which blocks are live from accepted results
  always @(posedge clk) begin
    ffha_pkg::res_t r;
    logic op;
    if (rst_n && out_tvalid && out_tready && issued_op.size() > 0) begin
      r = ffha_pkg::res_t'(out_tdata[34:0]);
      op = issued_op.pop_front();
      if (op == ffha_pkg::OP_ALLOC && r.status == ffha_pkg::ST_OK)
        live_blocks.insert(live_blocks.size(), r.result_offset);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_item(logic op, logic [15:0] req, logic [15:0] blk);
    while (!calm && $urandom_range(0, 99) < 31) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {blk, req};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    issued_op.insert(issued_op.size(), op);
    if (op == ffha_pkg::OP_ALLOC) n_alloc++;
    else n_free++;
  endtask

  task automatic alloc_req(logic [15:0] req);
    send_item(ffha_pkg::OP_ALLOC, req, 16'($urandom));
  endtask

  task automatic free_blk(logic [15:0] blk);
    send_item(ffha_pkg::OP_FREE, 16'($urandom), blk);
  endtask

  // free a random live block, dropping it from the live set
  task automatic free_live();
    int k;
    logic [15:0] blk;
    k = $urandom_range(0, live_blocks.size() - 1);
    blk = live_blocks[k];
    live_blocks.delete(k);
    freed_blocks.insert(freed_blocks.size(), blk);
    free_blk(blk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0 || issued_op.size() != 0) @(posedge clk);
  endtask

  initial begin
    int pick;
    logic [15:0] sz;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: size limits, rounding, no fit, bad frees, heap-end merge
    alloc_req(16'd0);
    alloc_req(16'd32769);
    alloc_req(16'hFFFF);
    alloc_req(16'd1);
    alloc_req(16'd12);
    alloc_req(16'd13);
    alloc_req(16'd32768);
    alloc_req(16'd32768);      // too little free space left: no chunk fits
    free_blk(16'd2);
    free_blk(16'd65532);
    free_blk(16'd65520);
    free_blk(16'd8);           // inside a block: header word is not a valid size
    drain();
    while (live_blocks.size() > 0) free_live();  // last one merges to heap end
    drain();
    alloc_req(16'd32764);
    alloc_req(16'd32000);
    alloc_req(16'd200);
    drain();
    while (live_blocks.size() > 0) free_live();
    drain();

    for (int i = 0; i < RandItems; i++) begin
      calm = (i >= 300 && i < 450);
      if (i == 600) drain();   // let every result come home once
      pick = $urandom_range(0, 99);
      if (live_blocks.size() > 0 && pick < 45) begin
        free_live();
      end else if (pick < 49) begin
        free_blk(16'($urandom) | 16'd1);   // misaligned
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 80) sz = 16'($urandom_range(1, 256));
        else if (pick < 92) sz = 16'($urandom_range(257, 4096));
        else if (pick < 96) sz = 16'($urandom_range(4097, 32768));
        else sz = 16'($urandom);
        alloc_req(sz);
      end
    end
    calm = 1'b0;

    // stale and arbitrary frees last, as they may tangle the free list
    repeat (6) begin
      if (freed_blocks.size() > 0)
        free_blk(freed_blocks[$urandom_range(0, freed_blocks.size() - 1)]);
      free_blk(16'($urandom) & 16'hFFFC);
    end
    drain();
    repeat (300) @(posedge clk);

    $display("Ran %0d allocates and %0d frees, incl. size limits, no-fit,", n_alloc, n_free);
    $display("bad, stale and merging frees, with random stalls on both sides.");
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
